// ===== rtl/smr_pkg.sv =====
package smr_pkg;

  // matrix geometry
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int TOTAL_W     = 9;
  localparam int RING_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = CNT_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // walker directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_col;
    logic               last_flag;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_en;
    logic read_en;
    logic out_load;
  } smr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } smr_sts_t;

  // clamp a size register to 1..MAX_ROWS
  function automatic logic [CNT_W-1:0] eff_rows(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (cnt > CNT_W'(MAX_ROWS)) begin
      res = CNT_W'(MAX_ROWS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

  // clamp a size register to 1..MAX_COLS
  function automatic logic [CNT_W-1:0] eff_cols(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (cnt > CNT_W'(MAX_COLS)) begin
      res = CNT_W'(MAX_COLS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

// ===== rtl/spiral_matrix_readout.sv =====
// Spiral matrix readout.
// Input channel (in_valid / in_stall / in_item): a load transaction (mode 0)
// writes element_value at the next row-major position; a read transaction
// (mode 1) returns the next element of the clockwise spiral.
// Output channel (out_valid / out_stall / out_item): one transaction per
// read, carrying the value, its row and column, and last_flag on the final
// element; after it the walker and the load pointer restart at the top left.
// Config port (cfg_wr_en / cfg_index / cfg_data): index 0 is row_count,
// index 1 is col_count; a write also restarts the walker and load pointer.
// Loads and reads: a load is written in its accept cycle and the block stays
// idle for the next item. A read is issued to the registered read port of the
// matrix memory in the accept cycle; the sequencer then moves to S_READ, which
// loads the output register, and out_valid rises at that edge.
// Reset: sizes return to 4 by 4, walker and load pointer to the start; the
// matrix contents are kept and undefined until loaded.
// Receiver stall: the output register holds; loads are still taken, and a
// read waits in S_READ with in_stall high until the register frees.
module spiral_matrix_readout (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [smr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  smr_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output smr_pkg::out_item_t             out_item
);
  import smr_pkg::*;

  smr_cmd_t cmd;
  smr_sts_t sts;

  // sequencer
  smr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // walker, memory and output register
  smr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_value (in_item.element_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item)
  );

  // a read transaction holds off the input in the cycle after it is accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.mode == MODE_READ) |=> in_stall)
    else $error("input not held off after read transaction");

  // a load never produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.mode == MODE_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after load transaction");

  // a new result only follows a pending read
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without pending read");

endmodule

// ===== rtl/smr_ctrl.sv =====
module smr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_stall,
  input  smr_pkg::smr_sts_t sts,
  output smr_pkg::smr_cmd_t cmd
);
  import smr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r;
  logic state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load_en = 1'b1;
          end else begin
            cmd.read_en = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_READ: begin
        in_stall = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/smr_datapath.sv =====
module smr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [smr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [31:0]            element_value,
  input  smr_pkg::smr_cmd_t             cmd,
  output smr_pkg::smr_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output smr_pkg::out_item_t            out_item
);
  import smr_pkg::*;

  // configuration and walker state
  logic [CNT_W-1:0]   row_count_r;
  logic [CNT_W-1:0]   col_count_r;
  logic [ADDR_W-1:0]  load_ptr_r;
  logic [IDX_W-1:0]   row_r;
  logic [IDX_W-1:0]   col_r;
  logic [1:0]         dir_r;
  logic [RING_W-1:0]  ring_r;
  logic [TOTAL_W-1:0] emitted_r;

  logic [IDX_W-1:0]   row_nxt;
  logic [IDX_W-1:0]   col_nxt;
  logic [1:0]         dir_nxt;
  logic [RING_W-1:0]  ring_nxt;

  // read stage and output register
  logic signed [31:0] mem [STORE_DEPTH];
  logic signed [31:0] rd_data_r;
  logic [IDX_W-1:0]   rd_row_r;
  logic [IDX_W-1:0]   rd_col_r;
  logic               rd_last_r;
  logic               rd_zero_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [CNT_W-1:0]   rows;
  logic [CNT_W-1:0]   cols;
  logic [2*CNT_W-1:0] total_prod;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] load_ptr_inc;
  logic [TOTAL_W-1:0] emitted_inc;
  logic [CNT_W+IDX_W-1:0] addr_full;
  logic [ADDR_W-1:0]  rd_addr;
  logic               in_range;
  logic               is_last;
  logic [CNT_W:0]     row_w;
  logic [CNT_W:0]     col_w;
  logic [CNT_W:0]     ring_w;

  assign rows         = eff_rows(row_count_r);
  assign cols         = eff_cols(col_count_r);
  assign total_prod   = rows * cols;
  assign total        = total_prod[TOTAL_W-1:0];
  assign load_ptr_inc = TOTAL_W'(load_ptr_r) + TOTAL_W'(1);
  assign emitted_inc  = emitted_r + TOTAL_W'(1);
  assign is_last      = emitted_inc >= total;
  assign addr_full    = (CNT_W+IDX_W)'(row_r * cols) + (CNT_W+IDX_W)'(col_r);
  assign rd_addr      = addr_full[ADDR_W-1:0];
  assign in_range     = ({1'b0, row_r} < rows) && ({1'b0, col_r} < cols);

  assign row_w  = (CNT_W+1)'(row_r);
  assign col_w  = (CNT_W+1)'(col_r);
  assign ring_w = (CNT_W+1)'(ring_r);

  // clockwise walker step
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    dir_nxt  = dir_r;
    ring_nxt = ring_r;
    case (dir_r)
      DIR_RIGHT: begin
        if (col_w + ring_w + (CNT_W+1)'(1) < (CNT_W+1)'(cols)) begin
          col_nxt = col_r + IDX_W'(1);
        end else begin
          dir_nxt = DIR_DOWN;
          row_nxt = row_r + IDX_W'(1);
        end
      end
      DIR_DOWN: begin
        if (row_w + ring_w + (CNT_W+1)'(1) < (CNT_W+1)'(rows)) begin
          row_nxt = row_r + IDX_W'(1);
        end else begin
          dir_nxt = DIR_LEFT;
          if (col_r != '0) col_nxt = col_r - IDX_W'(1);
        end
      end
      DIR_LEFT: begin
        if (col_w > ring_w) begin
          col_nxt = col_r - IDX_W'(1);
        end else begin
          dir_nxt = DIR_UP;
          if (row_r != '0) row_nxt = row_r - IDX_W'(1);
        end
      end
      DIR_UP: begin
        if (row_w > ring_w + (CNT_W+1)'(1)) begin
          row_nxt = row_r - IDX_W'(1);
        end else begin
          dir_nxt  = DIR_RIGHT;
          ring_nxt = ring_r + RING_W'(1);
          col_nxt  = col_r + IDX_W'(1);
        end
      end
      default: begin
        dir_nxt = DIR_RIGHT;
      end
    endcase
  end

  // size registers, load pointer and walker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(4);
      col_count_r <= CNT_W'(4);
      load_ptr_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      dir_r       <= DIR_RIGHT;
      ring_r      <= '0;
      emitted_r   <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_ROW_COUNT) row_count_r <= cfg_data;
      if (cfg_index == REG_COL_COUNT) col_count_r <= cfg_data;
      load_ptr_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      dir_r      <= DIR_RIGHT;
      ring_r     <= '0;
      emitted_r  <= '0;
    end else if (cmd.load_en) begin
      load_ptr_r <= (load_ptr_inc >= total) ? '0 : load_ptr_inc[ADDR_W-1:0];
    end else if (cmd.read_en) begin
      if (is_last) begin
        load_ptr_r <= '0;
        row_r      <= '0;
        col_r      <= '0;
        dir_r      <= DIR_RIGHT;
        ring_r     <= '0;
        emitted_r  <= '0;
      end else begin
        row_r     <= row_nxt;
        col_r     <= col_nxt;
        dir_r     <= dir_nxt;
        ring_r    <= ring_nxt;
        emitted_r <= emitted_inc;
      end
    end
  end

  // matrix memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem[load_ptr_r] <= element_value;
    end
    if (cmd.read_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // position of the pending read
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_row_r  <= row_r;
      rd_col_r  <= col_r;
      rd_last_r <= is_last;
      rd_zero_r <= !in_range;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.out_value <= rd_zero_r ? 32'sd0 : rd_data_r;
      out_item_r.out_row   <= rd_row_r;
      out_item_r.out_col   <= rd_col_r;
      out_item_r.last_flag <= rd_last_r;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

// ===== test/smr_readout_checker.sv =====
module smr_readout_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [smr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  smr_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  smr_pkg::out_item_t             out_item,
  output int                             mismatch_count,
  output int                             waiting_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import smr_pkg::*;

  localparam int PRINT_CAP = 40;

  // mirrored block state
  logic signed [31:0] element_mem [STORE_DEPTH];
  logic [CNT_W-1:0]   row_reg;
  logic [CNT_W-1:0]   col_reg;
  logic [TOTAL_W-1:0] load_ptr;
  logic [TOTAL_W-1:0] read_cnt;
  logic [IDX_W-1:0]   walk_row;
  logic [IDX_W-1:0]   walk_col;
  logic [1:0]         walk_dir;
  logic [RING_W-1:0]  walk_ring;

  // spiral elements still owed by the block, oldest first
  out_item_t spiral_q[$];

  // out-of-range sizes act as the nearest legal size
  function automatic int clamp_count(input logic [CNT_W-1:0] cnt, input int max_cnt);
    if (cnt == '0) begin
      return 1;
    end
    if (int'(cnt) > max_cnt) begin
      return max_cnt;
    end
    return int'(cnt);
  endfunction

  // walker and load pointer back to the top left
  task automatic restart_walk();
    load_ptr  = '0;
    read_cnt  = '0;
    walk_row  = '0;
    walk_col  = '0;
    walk_dir  = DIR_RIGHT;
    walk_ring = '0;
  endtask

  task automatic report_bad(input string what, input logic [31:0] got_v,
                            input logic [31:0] exp_v);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: %s: got %0h expected %0h", $time, what, got_v, exp_v);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    int rows;
    int cols;
    int total;
    int addr;
    out_item_t exp_item;
    if (!rst_n) begin
      row_reg = CNT_W'(4);
      col_reg = CNT_W'(4);
      restart_walk();
      spiral_q.delete();
    end else begin
      rows  = clamp_count(row_reg, MAX_ROWS);
      cols  = clamp_count(col_reg, MAX_COLS);
      total = rows * cols;

      // result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (spiral_q.size() == 0) begin
          report_bad("result with no read waiting", out_item.out_value, '0);
        end else begin
          exp_item = spiral_q.pop_front();
          if (out_item.out_value !== exp_item.out_value) begin
            report_bad("out_value", out_item.out_value, exp_item.out_value);
          end
          if (out_item.out_row !== exp_item.out_row) begin
            report_bad("out_row", 32'(out_item.out_row), 32'(exp_item.out_row));
          end
          if (out_item.out_col !== exp_item.out_col) begin
            report_bad("out_col", 32'(out_item.out_col), 32'(exp_item.out_col));
          end
          if (out_item.last_flag !== exp_item.last_flag) begin
            report_bad("last_flag", 32'(out_item.last_flag), 32'(exp_item.last_flag));
          end
        end
      end

      // register writes restart the walk, the matrix is kept
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ROW_COUNT: begin
            row_reg = cfg_data;
            restart_walk();
          end
          REG_COL_COUNT: begin
            col_reg = cfg_data;
            restart_walk();
          end
          default: ;
        endcase
      end

      // input transaction
      if (in_valid && !in_stall) begin
        if (in_item.mode == MODE_LOAD) begin
          element_mem[load_ptr] = in_item.element_value;
          load_ptr = load_ptr + 1'b1;
          if (int'(load_ptr) >= total) begin
            load_ptr = '0;
          end
        end else begin
          addr = int'(walk_row) * cols + int'(walk_col);
          exp_item.out_value = (int'(walk_row) < rows && int'(walk_col) < cols) ?
                               element_mem[addr] : '0;
          exp_item.out_row   = walk_row;
          exp_item.out_col   = walk_col;
          read_cnt           = read_cnt + 1'b1;
          exp_item.last_flag = (int'(read_cnt) >= total);
          spiral_q.insert(spiral_q.size(), exp_item);
          if (exp_item.last_flag) begin
            restart_walk();
          end else begin
            // clockwise step within the current ring, then one ring in
            case (walk_dir)
              DIR_RIGHT: begin
                if (int'(walk_col) + 1 + int'(walk_ring) < cols) begin
                  walk_col++;
                end else begin
                  walk_dir = DIR_DOWN;
                  walk_row++;
                end
              end
              DIR_DOWN: begin
                if (int'(walk_row) + int'(walk_ring) + 1 < rows) begin
                  walk_row++;
                end else begin
                  walk_dir = DIR_LEFT;
                  if (walk_col > 0) walk_col--;
                end
              end
              DIR_LEFT: begin
                if (int'(walk_col) > int'(walk_ring)) begin
                  walk_col--;
                end else begin
                  walk_dir = DIR_UP;
                  if (walk_row > 0) walk_row--;
                end
              end
              default: begin
                if (int'(walk_row) > int'(walk_ring) + 1) begin
                  walk_row--;
                end else begin
                  walk_dir = DIR_RIGHT;
                  walk_ring++;
                  walk_col++;
                end
              end
            endcase
          end
        end
      end
    end
    waiting_count <= spiral_q.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smr_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 100000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  int mismatch_count;
  int waiting_count;
  int cycle_count = 0;

  // sender gap and receiver stall rates in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  // stimulus-side view of the load pointer, so reads never hit unloaded words
  int sent_items    = 0;
  int plan_total    = 16;
  int plan_load_ptr = 0;
  int plan_reads    = 0;
  bit loaded_map [STORE_DEPTH];

  spiral_matrix_readout u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  smr_readout_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .waiting_count  (waiting_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int clamp_count(input logic [CNT_W-1:0] cnt, input int max_cnt);
    if (cnt == '0) begin
      return 1;
    end
    if (int'(cnt) > max_cnt) begin
      return max_cnt;
    end
    return int'(cnt);
  endfunction

  // mostly random words, with the signed extremes mixed in
  function automatic logic [31:0] random_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly small sizes, sometimes zero, the maximum or beyond it
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'(16);
      2:       return CFG_DATA_W'($urandom_range(17, 31));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  // every address the walker can visit has been loaded
  function automatic bit matrix_ready();
    for (int k = 0; k < plan_total; k++) begin
      if (!loaded_map[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // one input transaction, with random sender gaps in front of it
  task automatic send_item(input logic mode, input logic [31:0] value);
    in_item_t item;
    item.mode          = mode;
    item.element_value = value;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (mode == MODE_LOAD) begin
      loaded_map[plan_load_ptr] = 1'b1;
      plan_load_ptr++;
      if (plan_load_ptr >= plan_total) plan_load_ptr = 0;
    end else begin
      plan_reads++;
      if (plan_reads >= plan_total) begin
        plan_reads    = 0;
        plan_load_ptr = 0;
      end
    end
  endtask

  // wait until every read has come back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] rows,
                          input logic [CFG_DATA_W-1:0] cols);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    plan_total    = clamp_count(rows, MAX_ROWS) * clamp_count(cols, MAX_COLS);
    plan_load_ptr = 0;
    plan_reads    = 0;
  endtask

  task automatic load_items(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(MODE_LOAD, random_word());
    end
  endtask

  task automatic read_items(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(MODE_READ, $urandom());
    end
  endtask

  // a full matrix load followed by the whole spiral
  task automatic full_pass();
    load_items(plan_total);
    read_items(plan_total);
  endtask

  // loads and reads mixed at random, reads only once the matrix is loaded
  task automatic noise(input int n);
    logic mode;
    for (int k = 0; k < n; k++) begin
      mode = 1'($urandom_range(1));
      if (mode == MODE_READ && !matrix_ready()) mode = MODE_LOAD;
      send_item(mode, (mode == MODE_READ) ? $urandom() : random_word());
    end
  endtask

  initial begin : stimulus
    int mode_end [3];
    logic [CFG_DATA_W-1:0] r;
    logic [CFG_DATA_W-1:0] c;
    int kind;
    mode_end[0] = 150;
    mode_end[1] = 300;
    mode_end[2] = 850;
    idle_pct  = 19;
    stall_pct = 47;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size 4x4: signed extremes, then a spiral cut short by a size write
    for (int k = 0; k < 16; k++) begin
      case (k % 4)
        0:       send_item(MODE_LOAD, 32'h8000_0000 + 32'(k));
        1:       send_item(MODE_LOAD, 32'h7fff_ffff - 32'(k));
        2:       send_item(MODE_LOAD, 32'(k - 2));
        default: send_item(MODE_LOAD, 32'(2 - k));
      endcase
    end
    read_items(5);

    // zero sizes act as 1x1: extra load wraps, every read is the last
    set_size('0, '0);
    send_item(MODE_LOAD, 32'h8000_0000);
    send_item(MODE_LOAD, 32'h7fff_ffff);
    read_items(2);

    // random sets under three idle profiles
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          idle_pct  = 19;
          stall_pct = 47;
        end
        1: begin
          idle_pct  = 47;
          stall_pct = 19;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
          // the largest matrix once, columns given beyond the maximum
          set_size(CFG_DATA_W'(16), CFG_DATA_W'(31));
          full_pass();
        end
      endcase
      while (sent_items < mode_end[m]) begin
        r = pick_size();
        c = pick_size();
        if (clamp_count(r, MAX_ROWS) * clamp_count(c, MAX_COLS) > 64) begin
          c = CFG_DATA_W'($urandom_range(1, 4));
        end
        set_size(r, c);
        kind = $urandom_range(9);
        if (kind < 6) begin
          full_pass();
          if (kind == 0) read_items(plan_total);
        end else if (kind < 8) begin
          load_items(plan_total);
          read_items($urandom_range(0, plan_total - 1));
          noise($urandom_range(4, 12));
        end else begin
          noise($urandom_range(8, 30));
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
